// ===== hw/rtl/vrt_pkg.sv =====
package vrt_pkg;

  localparam int MaxStepsDefault     = 64;
  localparam int TimeFracBitsDefault = 24;

  localparam int StartW  = 24;
  localparam int OffsetW = 14;
  localparam int CoordW  = 16;
  localparam int IndexW  = 6;
  localparam int TimeW   = 32;
  localparam int InDataW = 3 * StartW + 3 * OffsetW;
  localparam int InBytesW = ((InDataW + 7) / 8) * 8;
  localparam int OutDataW = 3 * CoordW + IndexW;
  localparam int OutBytesW = ((OutDataW + 7) / 8) * 8;

  localparam logic [TimeW-1:0] TimeInf = '1;

  // One classified ray, as handed from the front part to the walker.
  typedef struct packed {
    logic [2:0][CoordW-1:0] voxel;
    logic [2:0][TimeW-1:0]  t_next;
    logic [2:0][TimeW-1:0]  t_inc;
    logic [2:0]             neg;
  } ray_t;

endpackage

// ===== hw/rtl/vrt_setup.sv =====
// Front part: per axis, reciprocal of |offset| by restoring division, one
// quotient bit a cycle, then the first crossing time. Axes run in turn.
module vrt_setup #(
  parameter int TIME_FRAC_BITS = vrt_pkg::TimeFracBitsDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [vrt_pkg::InDataW-1:0]  in_data,
  output logic                         ray_valid,
  input  logic                         ray_ready,
  output vrt_pkg::ray_t                ray
);
  import vrt_pkg::*;

  localparam int NumW = TIME_FRAC_BITS + 9;
  localparam int CntW = $clog2(NumW + 1);
  // The quotient register is kept at least one bit wider than a time value.
  localparam int QuotW = (NumW > TimeW) ? NumW : TimeW + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_MUL  = 5'b00100,
    S_NEXT = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state;
  logic [1:0] axis;
  logic [CntW-1:0] cnt;
  logic [QuotW-1:0] quot;
  logic [OffsetW:0] rem;
  logic [OffsetW-1:0] mag;
  logic [8:0] bound_dist;
  logic [40:0] prod;
  logic [InDataW-1:0] held;
  ray_t r;

  logic [StartW-1:0] s_a;
  logic [OffsetW-1:0] o_a;
  logic [TimeW-1:0] inc_sat;

  always_comb begin
    case (axis)
      2'd0: begin
        s_a = held[StartW-1:0];
        o_a = held[3*StartW +: OffsetW];
      end
      2'd1: begin
        s_a = held[StartW +: StartW];
        o_a = held[3*StartW+OffsetW +: OffsetW];
      end
      default: begin
        s_a = held[2*StartW +: StartW];
        o_a = held[3*StartW+2*OffsetW +: OffsetW];
      end
    endcase
    if (quot[QuotW-1:TimeW] != '0) inc_sat = TimeInf;
    else inc_sat = quot[TimeW-1:0];
    if (mag == '0) inc_sat = TimeInf;
  end

  assign in_ready = (state == S_IDLE);
  assign ray_valid = (state == S_OUT);
  assign ray = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            held <= in_data;
            axis <= 2'd0;
            if (in_data[3*StartW +: 3*OffsetW] != '0) state <= S_MUL;
          end
        end
        S_MUL: begin
          // Latch axis operands and start the division.
          mag <= o_a[OffsetW-1] ? OffsetW'(-o_a) : o_a;
          bound_dist <= o_a[OffsetW-1] ? {1'b0, s_a[7:0]} : 9'd256 - {1'b0, s_a[7:0]};
          r.neg[axis] <= o_a[OffsetW-1];
          r.voxel[axis] <= s_a[8 +: CoordW];
          rem <= '0;
          quot <= '0;
          cnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          // Numerator is 256 << TIME_FRAC_BITS: a single one bit at the top.
          if (cnt == CntW'(NumW)) begin
            r.t_inc[axis] <= inc_sat;
            prod <= 41'(bound_dist) * 41'(inc_sat);
            state <= S_NEXT;
          end else begin
            logic [OffsetW:0] rs;
            rs = {rem[OffsetW-1:0], (cnt == '0)};
            if (rs >= {1'b0, mag} && mag != '0) begin
              rem <= rs - {1'b0, mag};
              quot <= {quot[QuotW-2:0], 1'b1};
            end else begin
              rem <= rs;
              quot <= {quot[QuotW-2:0], 1'b0};
            end
            cnt <= cnt + 1'b1;
          end
        end
        S_NEXT: begin
          r.t_next[axis] <= prod[40] ? TimeInf : prod[8 +: TimeW];
          if (axis == 2'd2) state <= S_OUT;
          else begin
            axis <= axis + 2'd1;
            state <= S_MUL;
          end
        end
        S_OUT: if (ray_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/vrt_queue.sv =====
// Two-entry queue between setup and walker.
module vrt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  vrt_pkg::ray_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output vrt_pkg::ray_t rd_data
);
  import vrt_pkg::*;

  ray_t mem [2];
  logic wp, rp;
  logic [1:0] count;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wp] <= wr_data;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= '0;
    end else begin
      if (wr_valid && wr_ready) wp <= ~wp;
      if (rd_valid && rd_ready) rp <= ~rp;
      count <= count + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end
endmodule

// ===== hw/rtl/vrt_walk.sv =====
// Back part: steps one voxel per output transfer.
module vrt_walk #(
  parameter int MAX_STEPS      = vrt_pkg::MaxStepsDefault,
  parameter int TIME_FRAC_BITS = vrt_pkg::TimeFracBitsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          ray_valid,
  output logic                          ray_ready,
  input  vrt_pkg::ray_t                 ray,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vrt_pkg::OutBytesW-1:0] out_data,
  output logic                          out_last,
  output logic                          out_truncated
);
  import vrt_pkg::*;

  localparam int CntW = $clog2(MAX_STEPS + 1);

  logic busy;
  ray_t cur;
  logic [CntW-1:0] n;
  logic [1:0] pick;
  logic [TimeW:0] t_sum;
  logic done_t, done_n;

  always_comb begin
    if (cur.t_next[0] < cur.t_next[1] && cur.t_next[0] < cur.t_next[2]) pick = 2'd0;
    else if (cur.t_next[1] < cur.t_next[2]) pick = 2'd1;
    else pick = 2'd2;
    t_sum = {1'b0, cur.t_next[pick]} + {1'b0, cur.t_inc[pick]};
    if (TIME_FRAC_BITS >= TimeW) done_t = 1'b0;
    else done_t = (cur.t_next[pick] >> TIME_FRAC_BITS) != '0;
    done_n = (n == CntW'(MAX_STEPS - 1));
  end

  assign ray_ready = !busy;
  assign out_valid = busy;
  assign out_last = done_t || done_n;
  assign out_truncated = done_n && !done_t;
  assign out_data = OutBytesW'({IndexW'(n), cur.voxel[2], cur.voxel[1], cur.voxel[0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (!busy) begin
      if (ray_valid) begin
        cur <= ray;
        n <= '0;
        busy <= 1'b1;
      end
    end else if (out_ready) begin
      if (out_last) busy <= 1'b0;
      n <= n + 1'b1;
      cur.voxel[pick] <= cur.neg[pick] ? cur.voxel[pick] - 1'b1 : cur.voxel[pick] + 1'b1;
      cur.t_next[pick] <= t_sum[TimeW] ? TimeInf : t_sum[TimeW-1:0];
    end
  end
endmodule

// ===== hw/rtl/voxel_ray_traversal_3d.sv =====
// The time from an input transfer until the first voxel is offered is set by the bit-serial
// reciprocal that serves the three axes in turn.
// Throughput: one voxel per cycle while the walker streams and the output is ready; setup
// takes a new ray only after handing on the last one; rays overlap via a two-entry queue.
// An input whose three offsets are all zero is taken and gives no result.
// Reset: synchronous, active high; clears the setup state, the queue pointers and count, and the walker busy flag.
module voxel_ray_traversal_3d #(
  parameter int MAX_STEPS      = vrt_pkg::MaxStepsDefault,
  parameter int TIME_FRAC_BITS = vrt_pkg::TimeFracBitsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // start_x, start_y, start_z, offset_x, offset_y, offset_z from bit 0, zero pad
  input  logic [vrt_pkg::InBytesW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // voxel_x, voxel_y, voxel_z, visit_index from bit 0, zero pad
  output logic [vrt_pkg::OutBytesW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast,
  // truncated
  output logic                          m_axis_tuser
);
  import vrt_pkg::*;

  // Setup to queue, and queue to walker.
  logic f_valid, f_ready, b_valid, b_ready;
  ray_t f_ray, b_ray;

  vrt_setup #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_setup (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_data(s_axis_tdata[InDataW-1:0]),
    .ray_valid(f_valid), .ray_ready(f_ready), .ray(f_ray)
  );

  vrt_queue u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_ray),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_ray)
  );

  vrt_walk #(.MAX_STEPS(MAX_STEPS), .TIME_FRAC_BITS(TIME_FRAC_BITS)) u_walk (
    .clk, .rst,
    .ray_valid(b_valid), .ray_ready(b_ready), .ray(b_ray),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(m_axis_tdata), .out_last(m_axis_tlast), .out_truncated(m_axis_tuser)
  );
endmodule
